FILE: sv/htfd_pkg.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder package
// Shared constants, register indexes, result types and the CRC-8 step.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [15:0] RAW_T_BAD = 16'hFFFF;

  localparam logic [14:0] T_SCALE = 15'd17500;
  localparam logic [13:0] H_SCALE = 14'd10000;
  localparam logic signed [16:0] T_BIAS   = 17'sd4500;
  localparam logic signed [16:0] OFS_STEP = 17'sd10;
  localparam logic signed [16:0] H_MAX    = 17'sd9999;

  localparam logic [2:0] BYTE_T_HI = 3'd0;
  localparam logic [2:0] BYTE_T_LO = 3'd1;
  localparam logic [2:0] BYTE_CRC  = 3'd2;
  localparam logic [2:0] BYTE_H_HI = 3'd3;
  localparam logic [2:0] BYTE_H_LO = 3'd4;

  localparam logic REG_TEMP_OFS = 1'b0;
  localparam logic REG_HUM_OFS  = 1'b1;

  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic        crc_ok;
  } htfd_meas_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               frame_valid;
  } htfd_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/htfd_in_if.sv
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one received frame byte and its start flag.
// ----------------------------------------------------------------------------
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

FILE: sv/htfd_out_if.sv
// ----------------------------------------------------------------------------
// Measurement result channel
// Valid/ready channel carrying one decoded temperature and humidity result.
// ----------------------------------------------------------------------------
interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic               frame_valid;

  modport source (output valid, temperature_centi, humidity_centi, frame_valid, input ready);
  modport sink (input valid, temperature_centi, humidity_centi, frame_valid, output ready);
endinterface

FILE: sv/htfd_convert.sv
// ----------------------------------------------------------------------------
// Measurement conversion
// Scales raw readings to hundredths, applies the offsets and clamps humidity.
// ----------------------------------------------------------------------------
module htfd_convert
  import htfd_pkg::*;
(
  input  htfd_meas_t         meas,
  input  logic signed [7:0]  temp_ofs,
  input  logic signed [7:0]  hum_ofs,
  output htfd_result_t       res
);

  logic [30:0]        t_prod;
  logic [29:0]        h_prod;
  logic signed [16:0] t_ofs10;
  logic signed [16:0] h_ofs10;
  logic signed [16:0] t_sum;
  logic signed [16:0] h_sum;
  logic [13:0]        h_clamp;

  always_comb begin
    t_prod  = 31'(T_SCALE) * 31'(meas.raw_t);
    h_prod  = 30'(H_SCALE) * 30'(meas.raw_h);
    t_ofs10 = 17'(temp_ofs) * OFS_STEP;
    h_ofs10 = 17'(hum_ofs) * OFS_STEP;
    t_sum   = $signed({2'b00, t_prod[30:16]}) - T_BIAS + t_ofs10;
    h_sum   = $signed({3'b000, h_prod[29:16]}) + h_ofs10;
    if (h_sum < 17'sd0) begin
      h_clamp = '0;
    end else if (h_sum > H_MAX) begin
      h_clamp = H_MAX[13:0];
    end else begin
      h_clamp = h_sum[13:0];
    end
    res.frame_valid       = meas.crc_ok;
    res.temperature_centi = meas.crc_ok ? t_sum[14:0] : '0;
    res.humidity_centi    = meas.crc_ok ? h_clamp : '0;
  end

endmodule

FILE: sv/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder
// Assembles five-byte sensor frames, checks the temperature CRC-8 and gives
// one converted measurement per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  in_chan   sink       one frame byte and frame start flag per transfer
//  out_chan  source     temperature, humidity and validity per frame
//  APB       slave      two 8-bit offset registers at byte addresses 0 and 4
//
// One byte is taken in every cycle unless the input stalls; the result of the
// fifth byte passes through a capture register and the output register.
// Synchronous active-low reset clears the byte index and offsets and sets the CRC to its start value.
// A stalled result holds its register; the input stalls only when both
// result registers are full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  htfd_in_if.sink      in_chan,
  htfd_out_if.source   out_chan,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic signed [7:0] temp_ofs_r;
  logic signed [7:0] hum_ofs_r;

  logic [2:0]  idx_r;
  logic [2:0]  idx_nxt;
  logic [7:0]  crc_r;
  logic [7:0]  crc_nxt;
  logic [15:0] raw_t_r;
  logic [15:0] raw_t_nxt;
  logic [7:0]  rcv_crc_r;
  logic [7:0]  rcv_crc_nxt;
  logic [7:0]  h_hi_r;
  logic [7:0]  h_hi_nxt;
  logic [2:0]  idx_eff;
  logic        in_xfer;
  logic        frame_done;

  logic         s1_vld_r;
  htfd_meas_t   s1_meas_r;
  htfd_meas_t   s1_meas_nxt;
  logic         s1_adv;
  htfd_result_t conv_res;
  logic         out_vld_r;
  htfd_result_t out_res_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_ofs_r <= '0;
      hum_ofs_r  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TEMP_OFS: temp_ofs_r <= pwdata[7:0];
        REG_HUM_OFS:  hum_ofs_r  <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TEMP_OFS: prdata = {24'b0, temp_ofs_r};
      REG_HUM_OFS:  prdata = {24'b0, hum_ofs_r};
      default:      prdata = '0;
    endcase
  end

  assign s1_adv        = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || s1_adv;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    idx_eff     = (in_chan.frame_start || idx_r > BYTE_H_LO) ? BYTE_T_HI : idx_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    raw_t_nxt   = raw_t_r;
    rcv_crc_nxt = rcv_crc_r;
    h_hi_nxt    = h_hi_r;
    frame_done  = 1'b0;
    s1_meas_nxt.raw_t  = raw_t_r;
    s1_meas_nxt.raw_h  = {h_hi_r, in_chan.rx_byte};
    s1_meas_nxt.crc_ok = (crc_r == rcv_crc_r) && (raw_t_r != RAW_T_BAD);
    unique case (idx_eff)
      BYTE_T_HI: begin
        raw_t_nxt = {in_chan.rx_byte, raw_t_r[7:0]};
        crc_nxt   = crc8_byte(CRC_INIT, in_chan.rx_byte);
        idx_nxt   = BYTE_T_LO;
      end
      BYTE_T_LO: begin
        raw_t_nxt = {raw_t_r[15:8], in_chan.rx_byte};
        crc_nxt   = crc8_byte(crc_r, in_chan.rx_byte);
        idx_nxt   = BYTE_CRC;
      end
      BYTE_CRC: begin
        rcv_crc_nxt = in_chan.rx_byte;
        idx_nxt     = BYTE_H_HI;
      end
      BYTE_H_HI: begin
        h_hi_nxt = in_chan.rx_byte;
        idx_nxt  = BYTE_H_LO;
      end
      default: begin
        frame_done = 1'b1;
        idx_nxt    = BYTE_T_HI;
        crc_nxt    = CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= BYTE_T_HI;
      crc_r     <= CRC_INIT;
      raw_t_r   <= '0;
      rcv_crc_r <= '0;
      h_hi_r    <= '0;
    end else if (in_xfer) begin
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      raw_t_r   <= raw_t_nxt;
      rcv_crc_r <= rcv_crc_nxt;
      h_hi_r    <= h_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer && frame_done) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && frame_done) begin
      s1_meas_r <= s1_meas_nxt;
    end
  end

  htfd_convert u_convert (
    .meas     (s1_meas_r),
    .temp_ofs (temp_ofs_r),
    .hum_ofs  (hum_ofs_r),
    .res      (conv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_res_r <= conv_res;
    end
  end

  assign out_chan.valid             = out_vld_r;
  assign out_chan.temperature_centi = out_res_r.temperature_centi;
  assign out_chan.humidity_centi    = out_res_r.humidity_centi;
  assign out_chan.frame_valid       = out_res_r.frame_valid;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= BYTE_H_LO)
    else $error("byte index beyond the last frame byte");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.frame_valid |->
      out_res_r.temperature_centi == 15'sd0 && out_res_r.humidity_centi == 14'd0)
    else $error("invalid frame result carries non-zero readings");

  a_hum_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_res_r.humidity_centi <= H_MAX[13:0])
    else $error("humidity result above the clamp limit");

  a_frame_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && frame_done |=> s1_vld_r)
    else $error("completed frame not captured");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Humidity and temperature frame decoder testbench
// Sends sensor frame bytes with random gaps and result back-pressure. A
// behavioural decoder predicts every reading, and each result transfer is
// compared with it field by field. The offset registers are swept between
// phases and read back.
// ----------------------------------------------------------------------------
module testbench
  import htfd_pkg::*;
();

  localparam int IDLE_PCT       = 24;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 5;

  localparam logic [2:0] TEMP_OFS_ADDR = {REG_TEMP_OFS, 2'b00};
  localparam logic [2:0] HUM_OFS_ADDR  = {REG_HUM_OFS, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } frame_byte_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  htfd_in_if  in_chan ();
  htfd_out_if out_chan ();

  humidity_temp_frame_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_byte_t  pending_bytes [$];
  htfd_result_t pending_readings [$];
  frame_byte_t  next_byte;

  logic [2:0]        dec_index;
  logic [7:0]        dec_crc;
  logic [15:0]       dec_raw_t;
  logic [7:0]        dec_rx_crc;
  logic [7:0]        dec_h_hi;
  logic signed [7:0] temp_ofs;
  logic signed [7:0] hum_ofs;

  bit calm;
  bit byte_taken;
  bit moved;
  int bytes_queued;
  int bytes_accepted;
  int readings_checked;
  int invalid_readings;
  int errors;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  function automatic logic [7:0] sensor_crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    int         i;
    c = crc;
    for (i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st);
    htfd_result_t r;
    logic [15:0]  raw_h;
    int           t_val;
    int           h_val;
    bit           ok;
    if (st || dec_index > BYTE_H_LO) begin
      dec_index = BYTE_T_HI;
      dec_crc   = CRC_INIT;
    end
    case (dec_index)
      BYTE_T_HI: begin
        dec_raw_t[15:8] = b;
        dec_crc         = sensor_crc8(CRC_INIT, b);
        dec_index       = BYTE_T_LO;
      end
      BYTE_T_LO: begin
        dec_raw_t[7:0] = b;
        dec_crc        = sensor_crc8(dec_crc, b);
        dec_index      = BYTE_CRC;
      end
      BYTE_CRC: begin
        dec_rx_crc = b;
        dec_index  = BYTE_H_HI;
      end
      BYTE_H_HI: begin
        dec_h_hi  = b;
        dec_index = BYTE_H_LO;
      end
      default: begin
        raw_h = {dec_h_hi, b};
        ok    = (dec_crc == dec_rx_crc) && (dec_raw_t != RAW_T_BAD);
        t_val = ((int'(T_SCALE) * int'(dec_raw_t)) >> 16) - int'(T_BIAS)
                + int'(temp_ofs) * int'(OFS_STEP);
        h_val = ((int'(H_SCALE) * int'(raw_h)) >> 16) + int'(hum_ofs) * int'(OFS_STEP);
        if (h_val < 0) begin
          h_val = 0;
        end else if (h_val > int'(H_MAX)) begin
          h_val = int'(H_MAX);
        end
        r.temperature_centi = ok ? t_val[14:0] : '0;
        r.humidity_centi    = ok ? h_val[13:0] : '0;
        r.frame_valid       = ok;
        if (!ok) begin
          invalid_readings++;
        end
        pending_readings.push_back(r);
        dec_index = BYTE_T_HI;
        dec_crc   = CRC_INIT;
      end
    endcase
  endtask

  task automatic check_reading();
    htfd_result_t want;
    if (pending_readings.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("Unexpected reading: temp %0d hum %0d valid %0b",
                 out_chan.temperature_centi, out_chan.humidity_centi, out_chan.frame_valid);
      end
    end else begin
      want = pending_readings.pop_front();
      readings_checked++;
      if (out_chan.temperature_centi !== want.temperature_centi ||
          out_chan.humidity_centi !== want.humidity_centi ||
          out_chan.frame_valid !== want.frame_valid) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("Reading %0d mismatch: expected temp %0d hum %0d valid %0b, got %0d %0d %0b",
                   readings_checked, want.temperature_centi, want.humidity_centi,
                   want.frame_valid, out_chan.temperature_centi,
                   out_chan.humidity_centi, out_chan.frame_valid);
        end
      end
    end
  endtask

  // Bytes are driven on the falling edge; a byte on offer stays until its transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || byte_taken) begin
      byte_taken = 1'b0;
      if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_byte = pending_bytes.pop_front();
        in_chan.valid       <= 1'b1;
        in_chan.rx_byte     <= next_byte.data;
        in_chan.frame_start <= next_byte.start;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    out_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        decode_byte(in_chan.rx_byte, in_chan.frame_start);
        byte_taken = 1'b1;
        bytes_accepted++;
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        check_reading();
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d readings outstanding",
                 quiet_cycles, pending_readings.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic start);
    frame_byte_t fb;
    fb.data  = data;
    fb.start = start;
    pending_bytes.push_back(fb);
    bytes_queued++;
  endtask

  task automatic queue_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                             input bit corrupt, input bit lead_start);
    logic [7:0] crc;
    crc = sensor_crc8(sensor_crc8(CRC_INIT, raw_t[15:8]), raw_t[7:0]);
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_byte(raw_t[15:8], lead_start);
    push_byte(raw_t[7:0], 1'b0);
    push_byte(crc, 1'b0);
    push_byte(raw_h[15:8], 1'b0);
    push_byte(raw_h[7:0], 1'b0);
  endtask

  // Mostly five-byte frames, some with a bad CRC; the rest are short runs of random bytes.
  task automatic queue_random_traffic(input int n);
    int          made;
    int          len;
    int          k;
    logic [15:0] rt;
    logic [15:0] rh;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 10) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          push_byte(8'($urandom_range(0, 255)),
                    (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
        end
        made += len;
      end else begin
        case ($urandom_range(0, 9))
          0:       rt = 16'h0000;
          1:       rt = 16'hFFFF;
          2:       rt = 16'hFFFE;
          default: rt = 16'($urandom_range(0, 16'hFFFF));
        endcase
        case ($urandom_range(0, 6))
          0:       rh = 16'h0000;
          1:       rh = 16'hFFFF;
          default: rh = 16'($urandom_range(0, 16'hFFFF));
        endcase
        queue_frame(rt, rh, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 85);
        made += 5;
      end
    end
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (bytes_accepted != bytes_queued || pending_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_offsets(input logic [7:0] t, input logic [7:0] h);
    logic [31:0] rd;
    apb_xfer(1'b1, TEMP_OFS_ADDR, {{24{t[7]}}, t}, rd);
    apb_xfer(1'b1, HUM_OFS_ADDR, {{24{h[7]}}, h}, rd);
    temp_ofs = t;
    hum_ofs  = h;
    apb_xfer(1'b0, TEMP_OFS_ADDR, '0, rd);
    if (rd[7:0] !== t) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("Temperature offset read back 0x%02h, expected 0x%02h", rd[7:0], t);
      end
    end
    apb_xfer(1'b0, HUM_OFS_ADDR, '0, rd);
    if (rd[7:0] !== h) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("Humidity offset read back 0x%02h, expected 0x%02h", rd[7:0], h);
      end
    end
  endtask

  initial begin
    logic [7:0] t_plan [PHASES];
    logic [7:0] h_plan [PHASES];
    int         ph;
    t_plan = '{8'h00, 8'h7F, 8'h80, 8'h81, 8'h00};
    h_plan = '{8'h00, 8'h7F, 8'h80, 8'h7F, 8'h00};
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_chan.valid       = 1'b0;
    in_chan.rx_byte     = '0;
    in_chan.frame_start = 1'b0;
    out_chan.ready      = 1'b0;
    calm                = 1'b0;
    dec_index           = BYTE_T_HI;
    dec_crc             = CRC_INIT;
    dec_raw_t           = '0;
    dec_rx_crc          = '0;
    dec_h_hi            = '0;
    temp_ofs            = '0;
    hum_ofs             = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        set_offsets(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (ph != 0) begin
        set_offsets(t_plan[ph], h_plan[ph]);
      end
      @(posedge clk);
      calm = (ph == 3);
      if (ph == 0) begin
        queue_frame(16'h0000, 16'h0000, 1'b0, 1'b1);
        queue_frame(16'hFFFF, 16'h8000, 1'b0, 1'b1);
        queue_frame(16'h6666, 16'hFFFF, 1'b1, 1'b1);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        queue_frame(16'hFFFE, 16'hFFFF, 1'b0, 1'b1);
        queue_frame(16'h1234, 16'h5555, 1'b0, 1'b0);
      end
      queue_frame(16'hFFFE, 16'hFFFF, 1'b0, 1'b1);
      queue_frame(16'h0000, 16'h0000, 1'b0, 1'b1);
      queue_random_traffic(50);
      drain();
      @(posedge clk);
      queue_random_traffic(45);
      drain();
    end

    $display("Checked %0d readings (%0d flagged invalid) decoded from %0d frame bytes,",
             readings_checked, invalid_readings, bytes_accepted);
    $display("over %0d offset settings including both extremes, with stalls on both sides.",
             PHASES);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/htfd_pkg.sv
sv/htfd_in_if.sv
sv/htfd_out_if.sv
sv/htfd_convert.sv
sv/humidity_temp_frame_decoder.sv
verif/testbench.sv
